// ----- design/ternary_dot_product_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// Ternary dot-product accumulator assertion macros
// Shared concurrent assertion forms, reset-qualified on an active-low reset.
// ----------------------------------------------------------------------------
`ifndef TERNARY_DOT_PRODUCT_ACCUMULATOR_DEFINES_SVH
`define TERNARY_DOT_PRODUCT_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication.
`define TDPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdpa: same-cycle check failed");

// Next-cycle implication.
`define TDPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdpa: next-cycle check failed");

`endif

// ----- design/tdpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Ternary dot-product accumulator package
// Widths, weight codes, queue types and the per-lane term function.
// ----------------------------------------------------------------------------
package tdpa_pkg;

  localparam int unsigned Lanes   = 4;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned WeightW = Lanes * CodeW;
  localparam int unsigned ActW    = 8;
  localparam int unsigned TermW   = ActW + 1;
  // Four terms of at most 128 in magnitude fit in ActW + 3 signed bits.
  localparam int unsigned GroupW  = ActW + 3;
  localparam int unsigned AccW    = 32;

  // Queue between the front and back parts.
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;
  localparam int unsigned QCntW   = 2;

  // Ternary weight codes; the other two codes contribute nothing.
  localparam logic [CodeW-1:0] CodeAdd = 2'd1;
  localparam logic [CodeW-1:0] CodeSub = 2'd2;

  typedef logic signed [ActW-1:0]   act_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [GroupW-1:0] group_t;
  typedef logic signed [AccW-1:0]   acc_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    group_t group_sum;
    logic   last;
  } q_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Signed contribution of one lane.
  function automatic term_t lane_term(input logic [CodeW-1:0] code, input act_t act);
    term_t ext;
    term_t res;
    ext = {act[ActW-1], act};
    unique case (code)
      CodeAdd: res = ext;
      CodeSub: res = -ext;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ----- design/tdpa_in_if.sv -----
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one weight byte and four activations.
// ----------------------------------------------------------------------------
interface tdpa_in_if;
  logic                       valid;
  logic                       ready;
  logic [tdpa_pkg::WeightW-1:0] weight_byte;
  tdpa_pkg::act_t             act_lane0;
  tdpa_pkg::act_t             act_lane1;
  tdpa_pkg::act_t             act_lane2;
  tdpa_pkg::act_t             act_lane3;
  logic                       last_group;

  modport source (
    output valid, weight_byte, act_lane0, act_lane1, act_lane2, act_lane3, last_group,
    input  ready
  );

  modport sink (
    input  valid, weight_byte, act_lane0, act_lane1, act_lane2, act_lane3, last_group,
    output ready
  );
endinterface

// ----- design/tdpa_out_if.sv -----
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying one finished dot product.
// ----------------------------------------------------------------------------
interface tdpa_out_if;
  logic           valid;
  logic           ready;
  tdpa_pkg::acc_t dot_sum;

  modport source (
    output valid, dot_sum,
    input  ready
  );

  modport sink (
    input  valid, dot_sum,
    output ready
  );
endinterface

// ----- design/tdpa_front.sv -----
// ----------------------------------------------------------------------------
// Front part
// Accepts requests, decodes the four ternary codes and reduces each group
// of four activations to one narrow signed partial sum for the queue.
// ----------------------------------------------------------------------------
module tdpa_front (
  tdpa_in_if.sink              in_i,
  input  tdpa_pkg::q_stat_t    q_stat_i,
  output logic                 push_o,
  output tdpa_pkg::q_entry_t   entry_o
);

  tdpa_pkg::act_t  acts [tdpa_pkg::Lanes];
  tdpa_pkg::term_t terms [tdpa_pkg::Lanes];
  tdpa_pkg::group_t group_sum;

  // A request is taken whenever the queue has room.
  assign in_i.ready = !q_stat_i.full;
  assign push_o     = in_i.valid && !q_stat_i.full;

  assign acts[0] = in_i.act_lane0;
  assign acts[1] = in_i.act_lane1;
  assign acts[2] = in_i.act_lane2;
  assign acts[3] = in_i.act_lane3;

  // Decode each lane's code and add the four terms.
  always_comb begin
    group_sum = '0;
    for (int i = 0; i < tdpa_pkg::Lanes; i++) begin
      terms[i]  = tdpa_pkg::lane_term(
                    in_i.weight_byte[i*tdpa_pkg::CodeW +: tdpa_pkg::CodeW], acts[i]);
      group_sum = group_sum + tdpa_pkg::group_t'(terms[i]);
    end
  end

  assign entry_o.group_sum = group_sum;
  assign entry_o.last      = in_i.last_group;

endmodule

// ----- design/tdpa_queue.sv -----
// ----------------------------------------------------------------------------
// Decoupling queue
// Two-entry first-in first-out store between the front and back parts.
// ----------------------------------------------------------------------------
module tdpa_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tdpa_pkg::q_entry_t   entry_i,
  input  logic                 pop_i,
  output tdpa_pkg::q_entry_t   entry_o,
  output tdpa_pkg::q_stat_t    stat_o
);

  tdpa_pkg::q_entry_t          mem_q [tdpa_pkg::QDepth];
  logic [tdpa_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [tdpa_pkg::QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [tdpa_pkg::QCntW-1:0]  count_q, count_d;
  logic                        do_push, do_pop;

  assign stat_o.full  = (count_q == tdpa_pkg::QCntW'(tdpa_pkg::QDepth));
  assign stat_o.empty = (count_q == '0);

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o = mem_q[rd_ptr_q];

endmodule

// ----- design/tdpa_back.sv -----
// ----------------------------------------------------------------------------
// Back part
// Drains partial sums from the queue into the 32-bit accumulator and holds
// each finished dot product in an output register until it is taken.
// ----------------------------------------------------------------------------
module tdpa_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tdpa_pkg::q_stat_t    q_stat_i,
  input  tdpa_pkg::q_entry_t   entry_i,
  output logic                 pop_o,
  tdpa_out_if.source           out_o
);

  tdpa_pkg::acc_t acc_q, acc_d;
  tdpa_pkg::acc_t sum_q, sum_d;
  logic           valid_q, valid_d;
  tdpa_pkg::acc_t new_sum;
  logic           slot_free;

  // The output slot can take a result if empty or emptying this cycle.
  assign slot_free = !valid_q || out_o.ready;
  // Partial groups never need the slot; the last group waits for it.
  assign pop_o     = !q_stat_i.empty && (!entry_i.last || slot_free);

  // The group sum is signed, so the cast sign-extends it to the accumulator.
  assign new_sum = acc_q + tdpa_pkg::acc_t'(entry_i.group_sum);

  // Accumulate, and on the last group load the output register and clear.
  always_comb begin
    acc_d   = acc_q;
    sum_d   = sum_q;
    valid_d = valid_q && !out_o.ready;
    if (pop_o) begin
      if (entry_i.last) begin
        acc_d   = '0;
        sum_d   = new_sum;
        valid_d = 1'b1;
      end else begin
        acc_d = new_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign out_o.valid   = valid_q;
  assign out_o.dot_sum = sum_q;

endmodule

// ----- design/ternary_dot_product_accumulator.sv -----
// ----------------------------------------------------------------------------
// Ternary dot-product accumulator
// Streams packed ternary weights against int8 activations into a wrapping
// 32-bit sum and emits one result per dot product.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle, each a weight byte with four
// 2-bit codes and four signed activations, and sustains that rate as long as
// the result side keeps up; only requests marked last_group produce a result.
// A finished sum becomes valid on the output after its last request is
// accepted: the request is written into the two-entry queue behind the
// decode logic, and the back part then pops it and loads the output
// register. While a result waits in the output register, the back part
// keeps accumulating requests of the next dot product, and only a second
// last_group stalls it, after which the queue fills and the input
// deasserts ready. The sum wraps modulo 2^32 and clears after each result.
module ternary_dot_product_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdpa_in_if.sink     in_i,
  tdpa_out_if.source  out_o
);

`include "ternary_dot_product_accumulator_defines.svh"

  tdpa_pkg::q_stat_t  q_stat;
  tdpa_pkg::q_entry_t push_entry;
  tdpa_pkg::q_entry_t pop_entry;
  logic               push;
  logic               pop;

  tdpa_front u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  tdpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .stat_o  (q_stat)
  );

  tdpa_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .entry_i  (pop_entry),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // The queue is never reported full and empty at once.
  `TDPA_ASSERT_IMPL(a_q_stat_sane, clk_i, rst_ni, 1'b1, !(q_stat.full && q_stat.empty))
  // An accepted request is in the queue on the next cycle.
  `TDPA_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, in_i.valid && in_i.ready, !q_stat.empty)
  // A last group is never drained over a stalled, occupied output register.
  `TDPA_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_o.valid && !out_o.ready,
                    !(pop && pop_entry.last))

endmodule
